/* rtl/sha_pkg.sv */
package sha_pkg;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} rsp_t;

	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_COMP,
		ST_EMIT
	} state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* rtl/sha_req_if.sv */
interface sha_req_if;
	logic          valid;
	logic          ready;
	sha_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sha_rsp_if.sv */
interface sha_rsp_if;
	logic          valid;
	logic          ready;
	sha_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/sha_queue.sv */
// Two-entry request queue between front and back.
module sha_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sha_pkg::req_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output sha_pkg::req_t pop_data
);
	sha_pkg::req_t mem_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

/* rtl/sha_core.sv */
// Compression core: one round per cycle, 16-word sliding schedule.
module sha_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] blk [16],
	input  logic        reinit,
	output logic        busy,
	output logic [31:0] hash [8]
);
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        fold_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] s0;
	logic [31:0] s1;
	logic [31:0] wn;

	assign busy = busy_q | fold_q;
	assign hash = h_q;

	always_comb begin
		t1 = v_q[7] + (sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha_pkg::ROUND_K[rnd_q] + w_q[0];
		t2 = (sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= h_q;
			w_q <= blk;
		end else if (busy_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= sha_pkg::INIT_H;
			rnd_q  <= 6'd0;
			busy_q <= 1'b0;
			fold_q <= 1'b0;
		end else begin
			fold_q <= 1'b0;
			if (reinit) begin
				h_q <= sha_pkg::INIT_H;
			end else if (fold_q) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= 6'd0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fold_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* rtl/sha_back.sv */
// Back end: block assembly, padding sequencer and digest output.
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  sha_pkg::req_t q_data,
	output logic          q_pop,
	sha_rsp_if.source     rsp
);
	sha_pkg::state_t st_q;
	sha_pkg::state_t st_d;
	logic [7:0]      blk_q [64];
	logic [63:0]     cnt_q;
	logic [5:0]      pos_q;
	logic [2:0]      li_q;
	logic [2:0]      oi_q;
	logic            fin_q;
	logic            core_start;
	logic            core_busy;
	logic            reinit;
	logic [31:0]     hash [8];
	logic [31:0]     blkw [16];
	logic            wr_en;
	logic [7:0]      wr_byte;
	logic            take;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			blkw[i] = {blk_q[4 * i], blk_q[4 * i + 1], blk_q[4 * i + 2], blk_q[4 * i + 3]};
		end
	end

	sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.blk    (blkw),
		.reinit (reinit),
		.busy   (core_busy),
		.hash   (hash)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			sha_pkg::ST_IDLE: begin
				if (take) begin
					if (q_data.cmd == sha_pkg::CMD_FINISH) begin
						if (pos_q == 6'd63) begin
							st_d = sha_pkg::ST_COMP;
						end else if (pos_q == 6'd55) begin
							// pad byte lands just before the length field
							st_d = sha_pkg::ST_LEN;
						end else begin
							st_d = sha_pkg::ST_PAD;
						end
					end else if (pos_q == 6'd63) begin
						st_d = sha_pkg::ST_COMP;
					end
				end
			end
			sha_pkg::ST_PAD: begin
				if (pos_q == 6'd63) begin
					st_d = sha_pkg::ST_COMP;
				end else if (pos_q == 6'd55) begin
					st_d = sha_pkg::ST_LEN;
				end
			end
			sha_pkg::ST_LEN: begin
				if (pos_q == 6'd63) begin
					st_d = sha_pkg::ST_COMP;
				end
			end
			sha_pkg::ST_COMP: begin
				if (!core_start && !core_busy) begin
					if (!fin_q) begin
						st_d = sha_pkg::ST_IDLE;
					end else if (li_q == 3'd7) begin
						st_d = sha_pkg::ST_EMIT;
					end else if (pos_q == sha_pkg::LEN_POS) begin
						st_d = sha_pkg::ST_LEN;
					end else begin
						st_d = sha_pkg::ST_PAD;
					end
				end
			end
			sha_pkg::ST_EMIT: begin
				if (rsp.ready && oi_q == 3'd7) begin
					st_d = sha_pkg::ST_IDLE;
				end
			end
			default: st_d = sha_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		take    = 1'b0;
		wr_en   = 1'b0;
		wr_byte = 8'h00;
		q_pop   = 1'b0;
		unique case (st_q)
			sha_pkg::ST_IDLE: begin
				take  = !q_empty;
				q_pop = !q_empty;
				wr_en = take;
				wr_byte = (q_data.cmd == sha_pkg::CMD_FINISH) ? sha_pkg::PAD_BYTE
					: q_data.data_byte;
			end
			sha_pkg::ST_PAD: begin
				wr_en   = 1'b1;
				wr_byte = 8'h00;
			end
			sha_pkg::ST_LEN: begin
				wr_en   = 1'b1;
				wr_byte = cnt_q[8 * (7 - li_q) +: 8];
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid               = (st_q == sha_pkg::ST_EMIT);
	assign rsp.payload.digest_word = hash[oi_q];
	assign rsp.payload.word_index  = oi_q;
	assign rsp.payload.last_word   = (oi_q == 3'd7);
	assign reinit = (st_q == sha_pkg::ST_EMIT) && rsp.ready && (oi_q == 3'd7);

	// bytes always arrive in block order, so shift them in; byte 0 ends at the head
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < 63; i++) begin
				blk_q[i] <= blk_q[i + 1];
			end
			blk_q[63] <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= sha_pkg::ST_IDLE;
			cnt_q      <= 64'd0;
			pos_q      <= 6'd0;
			li_q       <= 3'd0;
			oi_q       <= 3'd0;
			fin_q      <= 1'b0;
			core_start <= 1'b0;
		end else begin
			st_q       <= st_d;
			core_start <= wr_en && (pos_q == 6'd63);
			if (wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (take) begin
				if (q_data.cmd == sha_pkg::CMD_FINISH) begin
					fin_q <= 1'b1;
					li_q  <= 3'd0;
				end else begin
					cnt_q <= cnt_q + 64'd8;
				end
			end
			// hold at the last length byte so the final block is recognized
			if (st_q == sha_pkg::ST_LEN && li_q != 3'd7) begin
				li_q <= li_q + 3'd1;
			end
			if (st_q == sha_pkg::ST_EMIT && rsp.ready) begin
				oi_q <= oi_q + 3'd1;
				if (oi_q == 3'd7) begin
					fin_q <= 1'b0;
					cnt_q <= 64'd0;
					pos_q <= 6'd0;
				end
			end
		end
	end
endmodule

/* rtl/sha256_message_hasher.sv */
// SHA-256 over a byte stream. Send requests with cmd=0 to append data_byte, and
// cmd=1 to pad the message and return the digest as eight 32-bit words, index 0
// first, last_word set on the eighth; the hasher then restarts for a new message.
// A two-entry queue decouples the request port from the back end. Each 64th
// byte starts a compression of 64 rounds at one round per cycle; the back end
// takes no bytes from the queue while a compression runs. Finish pads the
// message and runs one or two compressions before the digest words appear,
// one per cycle while the sink is ready.
module sha256_message_hasher (
	input logic       clk,
	input logic       arst_n,
	sha_req_if.sink   req,
	sha_rsp_if.source rsp
);
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	sha_pkg::req_t q_data;

	// front: accept whenever the queue has room
	assign req.ready = !q_full;

	sha_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req.valid && !q_full),
		.push_data (req.payload),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_data)
	);

	sha_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);
endmodule
